// File: src/gdo_pkg.sv
// Shared types, constants and calendar tables for the date offset block.
`timescale 1ns / 1ps
`default_nettype none

package gdo_pkg;

    // Default values of the top-level parameters
    localparam int unsigned MAX_YEAR_DEF    = 9999;
    localparam int unsigned OFFSET_BITS_DEF = 21;

    // Field widths of one date and of the result
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DATE_W  = YEAR_W + MONTH_W + DAY_W;
    localparam int DIST_W  = 22;

    // Serial day number of any 14-bit date fits here
    localparam int SER_W = 23;

    // Quotient by 100 of a 14-bit year: y * 5243 >> 19
    localparam int RECIP_W     = 13;
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int Q_W         = 8;

    // Day counts of the calendar cycles
    localparam int DAYS_400Y = 146097;
    localparam int DAYS_100Y = 36524;
    localparam int DAYS_4Y   = 1461;
    localparam int DAYS_1Y   = 365;
    localparam int DAYS_YEAR_MUL = 365;

    // Replacement for an invalid date
    localparam int DEF_YEAR = 1900;

    // Saturation value of the distance
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Sequencer program counter width
    localparam int PC_W = 5;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        UOP_NOP,
        UOP_LOAD_A,
        UOP_Q_Y,
        UOP_CHECK,
        UOP_Q_P,
        UOP_SERIAL,
        UOP_ADD_OFF,
        UOP_SET_ERR,
        UOP_SUB400,
        UOP_SUB100,
        UOP_SUB4,
        UOP_SUB1,
        UOP_YEAR_END,
        UOP_SUB_MON,
        UOP_SET_DATE,
        UOP_SAVE_A,
        UOP_SET_DIST,
        UOP_WRITE_OUT
    } t_uop;

    // Jump conditions
    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NEVER,
        C_NO_IN,
        C_OP_DIST,
        C_N_BAD,
        C_GE400,
        C_GE100,
        C_GE4,
        C_GE1,
        C_GE_MON,
        C_OUT_BUSY
    } t_cond;

    // When the step's operation fires
    typedef enum logic [1:0] {
        G_ALWAYS,
        G_TAKEN,
        G_NOT_TAKEN
    } t_gate;

    // One control word of the program
    typedef struct packed {
        t_uop              uop;
        t_cond             cnd;
        t_gate             gate;
        logic [PC_W-1:0]   target;
    } t_uword;

    // Status flags from the datapath to the sequencer
    typedef struct packed {
        logic no_in;
        logic op_dist;
        logic n_bad;
        logic ge400;
        logic ge100;
        logic ge4;
        logic ge1;
        logic ge_mon;
        logic out_busy;
    } t_flags;

    // Sequencer outputs to the datapath
    typedef struct packed {
        t_uop uop;
        logic idle;
    } t_ctl;

    // One result item
    typedef struct packed {
        logic                err;
        logic [DIST_W-1:0]   distance;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } t_result;

    // Length of a month in a common year, zero for a month code that means nothing
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of a month in a common year
    function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// File: src/gdo_seq.sv
// Microcode sequencer: program ROM, step counter and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none

module gdo_seq
    import gdo_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_flags i_flags,
    output t_ctl        o_ctl
);

    // Program addresses
    localparam logic [PC_W-1:0] PC_IDLE     = 5'd0;
    localparam logic [PC_W-1:0] PC_A_QY     = 5'd1;
    localparam logic [PC_W-1:0] PC_A_CHECK  = 5'd2;
    localparam logic [PC_W-1:0] PC_A_QP     = 5'd3;
    localparam logic [PC_W-1:0] PC_A_SERIAL = 5'd4;
    localparam logic [PC_W-1:0] PC_ADD_OFF  = 5'd5;
    localparam logic [PC_W-1:0] PC_RANGE    = 5'd6;
    localparam logic [PC_W-1:0] PC_L400     = 5'd7;
    localparam logic [PC_W-1:0] PC_L100     = 5'd8;
    localparam logic [PC_W-1:0] PC_L4       = 5'd9;
    localparam logic [PC_W-1:0] PC_L1       = 5'd10;
    localparam logic [PC_W-1:0] PC_YEAR_END = 5'd11;
    localparam logic [PC_W-1:0] PC_LMON     = 5'd12;
    localparam logic [PC_W-1:0] PC_SET_DATE = 5'd13;
    localparam logic [PC_W-1:0] PC_DIST     = 5'd14;
    localparam logic [PC_W-1:0] PC_B_QY     = 5'd15;
    localparam logic [PC_W-1:0] PC_B_CHECK  = 5'd16;
    localparam logic [PC_W-1:0] PC_B_QP     = 5'd17;
    localparam logic [PC_W-1:0] PC_B_SERIAL = 5'd18;
    localparam logic [PC_W-1:0] PC_SET_DIST = 5'd19;
    localparam logic [PC_W-1:0] PC_WRITE    = 5'd20;
    localparam logic [PC_W-1:0] PC_RETURN   = 5'd21;

    // Program ROM
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{uop: UOP_NOP, cnd: C_ALWAYS, gate: G_ALWAYS, target: PC_IDLE};
        case (pc)
            PC_IDLE:     w = '{UOP_LOAD_A,    C_NO_IN,    G_NOT_TAKEN, PC_IDLE};
            PC_A_QY:     w = '{UOP_Q_Y,       C_NEVER,    G_ALWAYS,    PC_IDLE};
            PC_A_CHECK:  w = '{UOP_CHECK,     C_NEVER,    G_ALWAYS,    PC_IDLE};
            PC_A_QP:     w = '{UOP_Q_P,       C_NEVER,    G_ALWAYS,    PC_IDLE};
            PC_A_SERIAL: w = '{UOP_SERIAL,    C_OP_DIST,  G_ALWAYS,    PC_DIST};
            PC_ADD_OFF:  w = '{UOP_ADD_OFF,   C_NEVER,    G_ALWAYS,    PC_IDLE};
            PC_RANGE:    w = '{UOP_SET_ERR,   C_N_BAD,    G_TAKEN,     PC_WRITE};
            PC_L400:     w = '{UOP_SUB400,    C_GE400,    G_TAKEN,     PC_L400};
            PC_L100:     w = '{UOP_SUB100,    C_GE100,    G_TAKEN,     PC_L100};
            PC_L4:       w = '{UOP_SUB4,      C_GE4,      G_TAKEN,     PC_L4};
            PC_L1:       w = '{UOP_SUB1,      C_GE1,      G_TAKEN,     PC_L1};
            PC_YEAR_END: w = '{UOP_YEAR_END,  C_NEVER,    G_ALWAYS,    PC_IDLE};
            PC_LMON:     w = '{UOP_SUB_MON,   C_GE_MON,   G_TAKEN,     PC_LMON};
            PC_SET_DATE: w = '{UOP_SET_DATE,  C_ALWAYS,   G_ALWAYS,    PC_WRITE};
            PC_DIST:     w = '{UOP_SAVE_A,    C_NEVER,    G_ALWAYS,    PC_IDLE};
            PC_B_QY:     w = '{UOP_Q_Y,       C_NEVER,    G_ALWAYS,    PC_IDLE};
            PC_B_CHECK:  w = '{UOP_CHECK,     C_NEVER,    G_ALWAYS,    PC_IDLE};
            PC_B_QP:     w = '{UOP_Q_P,       C_NEVER,    G_ALWAYS,    PC_IDLE};
            PC_B_SERIAL: w = '{UOP_SERIAL,    C_NEVER,    G_ALWAYS,    PC_IDLE};
            PC_SET_DIST: w = '{UOP_SET_DIST,  C_NEVER,    G_ALWAYS,    PC_IDLE};
            PC_WRITE:    w = '{UOP_WRITE_OUT, C_OUT_BUSY, G_NOT_TAKEN, PC_WRITE};
            PC_RETURN:   w = '{UOP_NOP,       C_ALWAYS,   G_ALWAYS,    PC_IDLE};
            default:     w = '{UOP_NOP,       C_ALWAYS,   G_ALWAYS,    PC_IDLE};
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          w_word;
    logic            w_taken;
    logic            w_exec;

    assign w_word = ucode(r_pc);

    // Condition select
    always_comb begin
        case (w_word.cnd)
            C_ALWAYS:   w_taken = 1'b1;
            C_NEVER:    w_taken = 1'b0;
            C_NO_IN:    w_taken = i_flags.no_in;
            C_OP_DIST:  w_taken = i_flags.op_dist;
            C_N_BAD:    w_taken = i_flags.n_bad;
            C_GE400:    w_taken = i_flags.ge400;
            C_GE100:    w_taken = i_flags.ge100;
            C_GE4:      w_taken = i_flags.ge4;
            C_GE1:      w_taken = i_flags.ge1;
            C_GE_MON:   w_taken = i_flags.ge_mon;
            C_OUT_BUSY: w_taken = i_flags.out_busy;
            default:    w_taken = 1'b0;
        endcase
    end

    // Operation gating
    always_comb begin
        case (w_word.gate)
            G_ALWAYS:    w_exec = 1'b1;
            G_TAKEN:     w_exec = w_taken;
            G_NOT_TAKEN: w_exec = !w_taken;
            default:     w_exec = 1'b0;
        endcase
    end

    assign n_pc       = w_taken ? w_word.target : r_pc + 1'b1;
    assign o_ctl.uop  = w_exec ? w_word.uop : UOP_NOP;
    assign o_ctl.idle = (r_pc == PC_IDLE);

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

// File: src/gregorian_date_offset.sv
// Top level: Gregorian date shift and day distance, microcoded datapath.
`timescale 1ns / 1ps
`default_nettype none

// Takes one request at a time: either date A moved by a signed day offset, or the absolute
// number of days between dates A and B. An invalid date (year 0, month outside 1..12, day
// outside the month) is read as 1900-01-01. A shifted date outside years 1..MAX_YEAR gives
// range_error with zero date fields; a distance saturates at 4194303. Both dates go to a
// serial day number and a shifted one is walked back to a date by a short microprogram
// that strips 400-year, century, four-year, year and month blocks one per cycle. A new
// request is taken only once the last one has been written to the output register. The
// result waits in that output register, and the write into it holds while the previous
// result is still unclaimed.
module gregorian_date_offset
    import gdo_pkg::*;
#(
    parameter int unsigned MAX_YEAR    = MAX_YEAR_DEF,
    parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic                                            i_clk,
    input  wire logic                                            i_rst_n,
    // year_a, month_a, day_a, offset_days, year_b, month_b, day_b (from bit 0 up)
    input  wire logic [((2*DATE_W+OFFSET_BITS+7)/8)*8-1:0]      i_s_tdata,
    // op
    input  wire logic                                            i_s_tuser,
    input  wire logic                                            i_s_tvalid,
    output logic                                                 o_s_tready,
    // res_year, res_month, res_day, distance_days (from bit 0 up)
    output logic [((DATE_W+DIST_W+7)/8)*8-1:0]                  o_m_tdata,
    // range_error
    output logic                                                 o_m_tuser,
    output logic                                                 o_m_tvalid,
    input  wire logic                                            i_m_tready
);

    // Serial day of (MAX_YEAR+1)-01-01: first day past the range
    localparam longint unsigned LIMIT = longint'(MAX_YEAR) * 365 + MAX_YEAR / 4
                                        - MAX_YEAR / 100 + MAX_YEAR / 400;

    localparam int OUT_DATA_W = ((DATE_W + DIST_W + 7) / 8) * 8;
    localparam int OFF_LO     = DATE_W;
    localparam int B_LO       = DATE_W + OFFSET_BITS;
    localparam int LIM_W      = $clog2(LIMIT + 1);
    localparam int SUM_W0     = (OFFSET_BITS > SER_W) ? OFFSET_BITS : SER_W;
    localparam int SUM_W      = ((LIM_W > SUM_W0) ? LIM_W : SUM_W0) + 2;
    localparam int YR_W       = ($clog2(MAX_YEAR + 1) > YEAR_W) ? $clog2(MAX_YEAR + 1) : YEAR_W;
    localparam int PROD_W     = YEAR_W + RECIP_W;

    localparam logic signed [SUM_W-1:0] K_LIMIT = SUM_W'(LIMIT);
    localparam logic signed [SUM_W-1:0] K400    = SUM_W'(DAYS_400Y);
    localparam logic signed [SUM_W-1:0] K100    = SUM_W'(DAYS_100Y);
    localparam logic signed [SUM_W-1:0] K4      = SUM_W'(DAYS_4Y);
    localparam logic signed [SUM_W-1:0] K1      = SUM_W'(DAYS_1Y);

    t_ctl   w_ctl;
    t_flags w_flags;

    // Latched request
    logic                          r_op;
    logic signed [OFFSET_BITS-1:0] r_off;
    logic [YEAR_W-1:0]             r_yb;
    logic [MONTH_W-1:0]            r_mb;
    logic [DAY_W-1:0]              r_db;

    // Working registers
    logic [YR_W-1:0]        r_y,    n_y;
    logic [MONTH_W-1:0]     r_m,    n_m;
    logic [DAY_W-1:0]       r_d,    n_d;
    logic [Q_W-1:0]         r_q,    n_q;
    logic                   r_leap, n_leap;
    logic [SER_W-1:0]       r_ser,  n_ser;
    logic [SER_W-1:0]       r_sa,   n_sa;
    logic signed [SUM_W-1:0] r_n,   n_n;
    logic [1:0]             r_cc,   n_cc;
    logic [4:0]             r_qq,   n_qq;
    logic [1:0]             r_yy,   n_yy;
    t_result                r_res,  n_res;

    // Output register
    t_result r_out;
    logic    r_out_valid;

    // Datapath terms
    logic [YEAR_W-1:0]  w_y14;
    logic [YEAR_W-1:0]  w_p;
    logic [YEAR_W-1:0]  w_q_src;
    logic [PROD_W-1:0]  w_prod;
    logic [YEAR_W-1:0]  w_rem;
    logic               w_leap_y;
    logic [DAY_W-1:0]   w_dim_chk;
    logic               w_valid;
    logic [SER_W:0]     w_ser_sum;
    logic [DAY_W-1:0]   w_dim_run;
    logic signed [SER_W:0] w_diff;
    logic [SER_W:0]     w_abs;
    logic               w_accept;

    gdo_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctl   (w_ctl)
    );

    assign o_s_tready = w_ctl.idle;
    assign w_accept   = i_s_tvalid && w_ctl.idle;

    // Year quotient by 100 (year itself, or year minus one for the serial)
    assign w_y14   = r_y[YEAR_W-1:0];
    assign w_p     = w_y14 - 1'b1;
    assign w_q_src = (w_ctl.uop == UOP_Q_P) ? w_p : w_y14;
    assign w_prod  = PROD_W'(w_q_src) * PROD_W'(RECIP_100);

    // Leap rule and date validity
    assign w_rem     = w_y14 - YEAR_W'(YEAR_W'(r_q) * YEAR_W'(100));
    assign w_leap_y  = (w_y14[1:0] == 2'd0) && ((w_rem != '0) || (r_q[1:0] == 2'd0));
    assign w_dim_chk = month_len(r_m) + DAY_W'((r_m == 4'd2) && w_leap_y);
    assign w_valid   = (w_y14 != '0) && (r_m >= 4'd1) && (r_m <= 4'd12)
                       && (r_d != '0) && (r_d <= w_dim_chk);

    // Serial day: p*365 + p/4 - p/100 + p/400 + days before month + day - 1
    assign w_ser_sum = (SER_W+1)'(w_p) * (SER_W+1)'(DAYS_YEAR_MUL)
                       + (SER_W+1)'(w_p >> 2)
                       - (SER_W+1)'(r_q)
                       + (SER_W+1)'(r_q >> 2)
                       + (SER_W+1)'(cum_days(r_m))
                       + (SER_W+1)'(r_leap && (r_m > 4'd2))
                       + (SER_W+1)'(r_d)
                       - (SER_W+1)'(1);

    // Month length during the month walk
    assign w_dim_run = month_len(r_m) + DAY_W'((r_m == 4'd2) && r_leap);

    // Distance
    assign w_diff = $signed({1'b0, r_sa}) - $signed({1'b0, r_ser});
    assign w_abs  = w_diff[SER_W] ? (SER_W+1)'(-w_diff) : (SER_W+1)'(w_diff);

    // Flags for the sequencer
    assign w_flags.no_in    = !i_s_tvalid;
    assign w_flags.op_dist  = r_op;
    assign w_flags.n_bad    = (r_n < 0) || (r_n >= K_LIMIT);
    assign w_flags.ge400    = (r_n >= K400);
    assign w_flags.ge100    = (r_cc != 2'd3) && (r_n >= K100);
    assign w_flags.ge4      = (r_n >= K4);
    assign w_flags.ge1      = (r_yy != 2'd3) && (r_n >= K1);
    assign w_flags.ge_mon   = (r_m != 4'd12) && (r_n >= $signed(SUM_W'(w_dim_run)));
    assign w_flags.out_busy = r_out_valid && !i_m_tready;

    // Datapath next state
    always_comb begin
        n_y    = r_y;
        n_m    = r_m;
        n_d    = r_d;
        n_q    = r_q;
        n_leap = r_leap;
        n_ser  = r_ser;
        n_sa   = r_sa;
        n_n    = r_n;
        n_cc   = r_cc;
        n_qq   = r_qq;
        n_yy   = r_yy;
        n_res  = r_res;
        case (w_ctl.uop)
            UOP_LOAD_A: begin
                n_y = YR_W'(i_s_tdata[0 +: YEAR_W]);
                n_m = i_s_tdata[YEAR_W +: MONTH_W];
                n_d = i_s_tdata[YEAR_W+MONTH_W +: DAY_W];
            end
            UOP_Q_Y, UOP_Q_P: begin
                n_q = Q_W'(w_prod >> RECIP_SHIFT);
            end
            UOP_CHECK: begin
                n_leap = w_valid && w_leap_y;
                if (!w_valid) begin
                    n_y = YR_W'(DEF_YEAR);
                    n_m = 4'd1;
                    n_d = 5'd1;
                end
            end
            UOP_SERIAL: begin
                n_ser = w_ser_sum[SER_W-1:0];
            end
            UOP_ADD_OFF: begin
                n_n  = $signed(SUM_W'(r_ser)) + SUM_W'(r_off);
                n_y  = '0;
                n_cc = '0;
                n_qq = '0;
                n_yy = '0;
            end
            UOP_SET_ERR: begin
                n_res     = '0;
                n_res.err = 1'b1;
            end
            UOP_SUB400: begin
                n_n = r_n - K400;
                n_y = r_y + YR_W'(400);
            end
            UOP_SUB100: begin
                n_n  = r_n - K100;
                n_y  = r_y + YR_W'(100);
                n_cc = r_cc + 2'd1;
            end
            UOP_SUB4: begin
                n_n  = r_n - K4;
                n_y  = r_y + YR_W'(4);
                n_qq = r_qq + 5'd1;
            end
            UOP_SUB1: begin
                n_n  = r_n - K1;
                n_y  = r_y + YR_W'(1);
                n_yy = r_yy + 2'd1;
            end
            UOP_YEAR_END: begin
                // last year of a four-year block is leap, except a century not of 400
                n_y    = r_y + YR_W'(1);
                n_m    = 4'd1;
                n_leap = (r_yy == 2'd3) && ((r_qq != 5'd24) || (r_cc == 2'd3));
            end
            UOP_SUB_MON: begin
                n_n = r_n - $signed(SUM_W'(w_dim_run));
                n_m = r_m + 4'd1;
            end
            UOP_SET_DATE: begin
                n_res       = '0;
                n_res.year  = YEAR_W'(r_y);
                n_res.month = r_m;
                n_res.day   = r_n[DAY_W-1:0] + 1'b1;
            end
            UOP_SAVE_A: begin
                n_sa = r_ser;
                n_y  = YR_W'(r_yb);
                n_m  = r_mb;
                n_d  = r_db;
            end
            UOP_SET_DIST: begin
                n_res          = '0;
                n_res.distance = (w_abs > (SER_W+1)'(DIST_MAX)) ? DIST_MAX
                                                                : w_abs[DIST_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_y    <= n_y;
        r_m    <= n_m;
        r_d    <= n_d;
        r_q    <= n_q;
        r_leap <= n_leap;
        r_ser  <= n_ser;
        r_sa   <= n_sa;
        r_n    <= n_n;
        r_cc   <= n_cc;
        r_qq   <= n_qq;
        r_yy   <= n_yy;
        r_res  <= n_res;
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_s_tuser;
            r_off <= i_s_tdata[OFF_LO +: OFFSET_BITS];
            r_yb  <= i_s_tdata[B_LO +: YEAR_W];
            r_mb  <= i_s_tdata[B_LO+YEAR_W +: MONTH_W];
            r_db  <= i_s_tdata[B_LO+YEAR_W+MONTH_W +: DAY_W];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.uop == UOP_WRITE_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.uop == UOP_WRITE_OUT) begin
            r_out <= r_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.err;
    assign o_m_tdata  = OUT_DATA_W'({r_out.distance, r_out.day, r_out.month, r_out.year});

`ifndef ASSERT_OFF
    // a written result shows up on the output
    a_write_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.uop == UOP_WRITE_OUT) |=> o_m_tvalid)
        else $error("written result not presented");

    // range error carries no date and no distance
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.err) |->
            (r_out.year == '0 && r_out.month == '0 && r_out.day == '0
             && r_out.distance == '0))
        else $error("range error with nonzero fields");

    // a shifted date has a nonzero day, a month of at most 12, no distance and no error
    a_date_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.month != '0) |->
            (r_out.day != '0 && r_out.month <= 4'd12 && r_out.distance == '0 && !r_out.err))
        else $error("malformed shifted date");

    // sequencer leaves idle right after taking a request
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("sequencer stayed idle after a request");
`endif

endmodule

`default_nettype wire
